### hw/rtl/sdsd_pkg.sv
// sdsd_pkg: shared types, codes and pattern tables of the segment display shift driver
// no dependencies; imported by every module of the block
`default_nettype none

package sdsd_pkg;

   // target / shift chain codes
   localparam logic [1:0] OP_DIGITS = 2'd0;
   localparam logic [1:0] OP_ALPHA  = 2'd1;
   localparam logic [1:0] OP_BAR    = 2'd2;

   localparam logic [1:0] DISP_DIGITS = 2'd0;
   localparam logic [1:0] DISP_ALPHA  = 2'd1;
   localparam logic [1:0] DISP_BAR    = 2'd2;

   // pin action codes
   localparam logic ACT_SHIFT = 1'b0;
   localparam logic ACT_LATCH = 1'b1;

   localparam int PAT_W      = 16;
   localparam int SHIFT_CNT_W = 5;
   localparam int MATCH_W    = 7;
   localparam int DIGITS_BITS = 16;
   localparam int ALPHA_BITS  = 12;
   localparam int BAR_STEPS   = 10;

   localparam logic [7:0]         DOT_MASK   = 8'h80;
   localparam logic [MATCH_W-1:0] MATCH_BASE = 7'd101;
   localparam logic [6:0]         PCT_MAX    = 7'd100;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] value;
      logic       dot_on;
      logic [6:0] brightness;
   } req_type;

   typedef struct packed {
      logic [1:0]         display;
      logic               action;
      logic               data_bit;
      logic               set_brightness;
      logic [MATCH_W-1:0] brightness_match;
      logic               last;
   } rsp_type;

   // one classified update, waiting for the shifter
   typedef struct packed {
      logic [1:0]             display;
      logic [PAT_W-1:0]       pattern;
      logic [SHIFT_CNT_W-1:0] shift_count;
      logic                   double_latch;
      logic                   set_brightness;
      logic [MATCH_W-1:0]     brightness_match;
   } cmd_type;

   function automatic logic [7:0] seg_digit(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'h3F;
         4'd1: pat = 8'h30;
         4'd2: pat = 8'h6D;
         4'd3: pat = 8'h79;
         4'd4: pat = 8'h72;
         4'd5: pat = 8'h5B;
         4'd6: pat = 8'h5F;
         4'd7: pat = 8'h31;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h7B;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   function automatic logic [11:0] alpha_pat(input logic [7:0] code);
      logic [11:0] pat;
      case (code) inside
         8'h41, 8'h61: pat = 12'h077;
         8'h42:        pat = 12'h639;
         8'h62:        pat = 12'h07C;
         8'h43, 8'h63: pat = 12'h039;
         8'h44:        pat = 12'h08F;
         8'h64:        pat = 12'h05E;
         8'h45, 8'h65: pat = 12'h079;
         8'h46, 8'h66: pat = 12'h071;
         8'h47, 8'h67: pat = 12'h439;
         8'h48:        pat = 12'h076;
         8'h68:        pat = 12'h074;
         8'h49:        pat = 12'h089;
         8'h69:        pat = 12'h080;
         8'h4A:        pat = 12'h01E;
         8'h6A:        pat = 12'h80E;
         8'h4B:        pat = 12'h670;
         8'h6B:        pat = 12'h680;
         8'h4C, 8'h6C: pat = 12'h038;
         8'h4D, 8'h6D: pat = 12'h336;
         8'h4E, 8'h6E: pat = 12'h536;
         8'h4F, 8'h6F: pat = 12'h03F;
         8'h50, 8'h70: pat = 12'h073;
         8'h51, 8'h71: pat = 12'h43F;
         8'h52, 8'h72: pat = 12'h473;
         8'h53, 8'h73: pat = 12'h06D;
         8'h54, 8'h74: pat = 12'h081;
         8'h55, 8'h75: pat = 12'h03E;
         8'h56:        pat = 12'hA30;
         8'h76:        pat = 12'h300;
         8'h57, 8'h77: pat = 12'hC36;
         8'h58, 8'h78: pat = 12'hF00;
         8'h59, 8'h79: pat = 12'h380;
         8'h5A, 8'h7A: pat = 12'hA49;
         8'h30:        pat = 12'h03F;
         8'h31:        pat = 12'h206;
         8'h32:        pat = 12'h05B;
         8'h33:        pat = 12'h04F;
         8'h34:        pat = 12'h066;
         8'h35:        pat = 12'h06D;
         8'h36:        pat = 12'h07D;
         8'h37:        pat = 12'h007;
         8'h38:        pat = 12'h07F;
         8'h39:        pat = 12'h06F;
         default:      pat = 12'h000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sdsd_front.sv
// sdsd_front: accepts display updates and turns each into a shift command
// depends on sdsd_pkg (types, codes, pattern tables)
`default_nettype none

module sdsd_front
   import sdsd_pkg::*;
(
   input  wire logic    start,
   input  wire logic    queue_full,
   input  wire req_type req,
   output logic         busy,
   output logic         push,
   output cmd_type      cmd
);

   logic [15:0] tens_prod;
   logic [4:0]  tens;
   logic [7:0]  tens_x10;
   logic [7:0]  units_wide;
   logic [7:0]  tens_pat;
   logic [7:0]  units_pat;
   logic [3:0]  bar_level;
   logic [BAR_STEPS-1:0] bar_bits;
   logic [6:0]  pct;

   always_comb begin
      // value / 10 via reciprocal, exact for 8-bit inputs
      tens_prod  = 16'(req.value) * 16'd205;
      tens       = tens_prod[15:11];
      tens_x10   = {tens, 3'b000} + {2'b00, tens, 1'b0};
      units_wide = req.value - tens_x10;
      tens_pat   = (tens < 5'd10) ? seg_digit(tens[3:0]) : 8'h00;
      if (req.dot_on) begin
         tens_pat = tens_pat | DOT_MASK;
      end
      units_pat  = seg_digit(units_wide[3:0]);

      bar_level = (req.value > 8'(BAR_STEPS)) ? 4'(BAR_STEPS) : req.value[3:0];
      bar_bits  = BAR_STEPS'((11'd1 << bar_level) - 11'd1);

      pct = (req.brightness > PCT_MAX) ? PCT_MAX : req.brightness;

      busy = queue_full;
      push = start && !queue_full;

      cmd.display          = DISP_DIGITS;
      cmd.pattern          = {tens_pat, units_pat};
      cmd.shift_count      = SHIFT_CNT_W'(DIGITS_BITS);
      cmd.double_latch     = req.dot_on;
      cmd.set_brightness   = 1'b1;
      cmd.brightness_match = MATCH_BASE - pct;

      unique case (req.operation)
         OP_DIGITS: begin
         end
         OP_ALPHA: begin
            cmd.display      = DISP_ALPHA;
            cmd.pattern      = {alpha_pat(req.value), 4'b0000};
            cmd.shift_count  = SHIFT_CNT_W'(ALPHA_BITS);
            cmd.double_latch = 1'b0;
         end
         OP_BAR: begin
            cmd.display          = DISP_BAR;
            cmd.pattern          = {bar_bits, (PAT_W - BAR_STEPS)'(0)};
            cmd.shift_count      = SHIFT_CNT_W'(BAR_STEPS);
            cmd.double_latch     = 1'b0;
            cmd.set_brightness   = 1'b0;
            cmd.brightness_match = '0;
         end
         default: begin
            // unused target: taken but produces nothing
            push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/sdsd_queue.sv
// sdsd_queue: short command fifo between the front and the shifter
// depends on sdsd_pkg (cmd_type, queue depth)
`default_nettype none

module sdsd_queue
   import sdsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         full,
   output logic         empty
);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      empty = (count_ff == '0);
      head  = entries_ff[rd_ptr_ff];
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/sdsd_back.sv
// sdsd_back: shifter that plays one command out as one pin action a cycle
// depends on sdsd_pkg (cmd_type, rsp_type, action codes)
`default_nettype none

module sdsd_back
   import sdsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type head,
   input  wire logic    empty,
   output logic         pop,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic                   active_ff, active_in;
   logic [1:0]             disp_ff, disp_in;
   logic [PAT_W-1:0]       sr_ff, sr_in;
   logic [SHIFT_CNT_W-1:0] shifts_left_ff, shifts_left_in;
   logic [1:0]             latches_left_ff, latches_left_in;
   logic                   first_ff, first_in;
   logic [MATCH_W-1:0]     match_ff, match_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   shifting;
   logic                   last_now;

   always_comb begin
      shifting = (shifts_left_ff != '0);
      last_now = active_ff && !shifting && (latches_left_ff == 2'd1);
      pop      = (!active_ff || last_now) && !empty;

      rsp_strobe_in                = active_ff;
      rsp_data_in.display          = disp_ff;
      rsp_data_in.action           = shifting ? ACT_SHIFT : ACT_LATCH;
      rsp_data_in.data_bit         = shifting && sr_ff[PAT_W-1];
      rsp_data_in.set_brightness   = first_ff;
      rsp_data_in.brightness_match = first_ff ? match_ff : '0;
      rsp_data_in.last             = last_now;

      active_in       = active_ff;
      disp_in         = disp_ff;
      sr_in           = sr_ff;
      shifts_left_in  = shifts_left_ff;
      latches_left_in = latches_left_ff;
      first_in        = first_ff;
      match_in        = match_ff;

      if (active_ff) begin
         first_in = 1'b0;
         if (shifting) begin
            sr_in          = {sr_ff[PAT_W-2:0], 1'b0};
            shifts_left_in = shifts_left_ff - 1'b1;
         end else begin
            latches_left_in = latches_left_ff - 1'b1;
         end
         if (last_now) begin
            active_in = 1'b0;
         end
      end

      if (pop) begin
         active_in       = 1'b1;
         disp_in         = head.display;
         sr_in           = head.pattern;
         shifts_left_in  = head.shift_count;
         latches_left_in = head.double_latch ? 2'd2 : 2'd1;
         first_in        = head.set_brightness;
         match_in        = head.brightness_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      disp_ff         <= disp_in;
      sr_ff           <= sr_in;
      shifts_left_ff  <= shifts_left_in;
      latches_left_ff <= latches_left_in;
      first_ff        <= first_in;
      match_ff        <= match_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/segment_display_shift_driver_core.sv
// segment_display_shift_driver_core: top level of the segment display shift driver
// depends on sdsd_pkg, sdsd_front, sdsd_queue, sdsd_back
// first pin action (queue empty, idle): queue write, shifter load, then the rsp_ register
// throughput: one pin action per cycle while commands are queued; an item is one shift
//    per pattern bit, then a latch (two for digits with dot); runs follow with no gap
// busy is high only while the two-entry command queue is full; results cannot be stalled
// reset (synchronous) empties the queue and idles the shifter; no result in the cycle after
`default_nettype none

module segment_display_shift_driver_core
   import sdsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   // front to queue
   logic    push;
   cmd_type push_cmd;
   // queue to shifter
   cmd_type head;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;

   // classify the update: patterns, bit count, latch count, brightness match
   sdsd_front u_front (
      .start      (start),
      .queue_full (queue_full),
      .req        (req_data),
      .busy       (busy),
      .push       (push),
      .cmd        (push_cmd)
   );

   // decouples item intake from the long serial run of the shifter
   sdsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // one pin action a cycle while a command runs; loads the next on its last action
   sdsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/sdsd_checker.sv
// sdsd_checker: port-level assertions for segment_display_shift_driver_core, with bind
// depends on sdsd_pkg (rsp_type, action codes)
`default_nettype none

module sdsd_checker
   import sdsd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe in cycle after reset");

   // a run is contiguous and stays on one chain until its last item
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> (rsp_strobe && $stable(rsp_data.display)))
      else $error("run broken or chain changed mid run");

   // a run always ends with a latch
   a_last_is_latch: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> (rsp_data.action == ACT_LATCH))
      else $error("run ended on a shift");

   // brightness is set only at the start of a run, with a match in range
   a_brightness_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.set_brightness) |->
         (rsp_data.brightness_match >= 7'd1 && rsp_data.brightness_match <= MATCH_BASE &&
          !$past(rsp_strobe && !rsp_data.last)))
      else $error("brightness update misplaced or out of range");

endmodule

bind segment_display_shift_driver_core sdsd_checker u_sdsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

### tb/sv/testbench.sv
// testbench: self-checking bench for segment_display_shift_driver_core
// depends on sdsd_pkg (types and codes) and the core rtl; predicts every pin action in a
// small scoreboard class and checks the strobed results in order
`timescale 1ns / 100ps

module testbench;
   import sdsd_pkg::*;

   // operation code that has no target and must produce no pin actions
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 260;
   localparam int MAX_GAP      = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FULL_PERCENT = 100;

   // expected pin actions, in the order the shifter must emit them
   class pin_action_board;
      rsp_type pending_actions[$];
      rsp_type run[$];
      int      mismatches;

      function logic [7:0] seven_seg(input int digit);
         case (digit)
            0: return 8'h3F;
            1: return 8'h30;
            2: return 8'h6D;
            3: return 8'h79;
            4: return 8'h72;
            5: return 8'h5B;
            6: return 8'h5F;
            7: return 8'h31;
            8: return 8'h7F;
            9: return 8'h7B;
            default: return 8'h00;
         endcase
      endfunction

      // 12-bit alphanumeric glyphs, blank for anything without a pattern
      function logic [11:0] char_glyph(input logic [7:0] code);
         case (code)
            "A", "a": return 12'h077;
            "B":      return 12'h639;
            "b":      return 12'h07C;
            "C", "c": return 12'h039;
            "D":      return 12'h08F;
            "d":      return 12'h05E;
            "E", "e": return 12'h079;
            "F", "f": return 12'h071;
            "G", "g": return 12'h439;
            "H":      return 12'h076;
            "h":      return 12'h074;
            "I":      return 12'h089;
            "i":      return 12'h080;
            "J":      return 12'h01E;
            "j":      return 12'h80E;
            "K":      return 12'h670;
            "k":      return 12'h680;
            "L", "l": return 12'h038;
            "M", "m": return 12'h336;
            "N", "n": return 12'h536;
            "O", "o": return 12'h03F;
            "P", "p": return 12'h073;
            "Q", "q": return 12'h43F;
            "R", "r": return 12'h473;
            "S", "s": return 12'h06D;
            "T", "t": return 12'h081;
            "U", "u": return 12'h03E;
            "V":      return 12'hA30;
            "v":      return 12'h300;
            "W", "w": return 12'hC36;
            "X", "x": return 12'hF00;
            "Y", "y": return 12'h380;
            "Z", "z": return 12'hA49;
            "0":      return 12'h03F;
            "1":      return 12'h206;
            "2":      return 12'h05B;
            "3":      return 12'h04F;
            "4":      return 12'h066;
            "5":      return 12'h06D;
            "6":      return 12'h07D;
            "7":      return 12'h007;
            "8":      return 12'h07F;
            "9":      return 12'h06F;
            default:  return 12'h000;
         endcase
      endfunction

      function void add_action(input logic [1:0] chain, input logic act, input logic level);
         rsp_type a;
         a = '0;
         a.display  = chain;
         a.action   = act;
         a.data_bit = level;
         run.push_back(a);
      endfunction

      // msb first
      function void shift_out(input logic [1:0] chain, input logic [15:0] pattern,
                              input int nbits);
         for (int i = nbits - 1; i >= 0; i--)
            add_action(chain, ACT_SHIFT, pattern[i]);
      endfunction

      function void note_item(input req_type item);
         logic [6:0] pct;
         logic [7:0] tens_pat;
         int         level;
         run.delete();
         pct = (item.brightness > FULL_PERCENT) ? 7'(FULL_PERCENT) : item.brightness;
         case (item.operation)
            OP_DIGITS: begin
               // tens digit 10..25 shifts blank, dot still applies
               tens_pat = seven_seg(int'(item.value) / 10);
               if (item.dot_on)
                  tens_pat = tens_pat | DOT_MASK;
               shift_out(DISP_DIGITS, {8'h00, tens_pat}, 8);
               shift_out(DISP_DIGITS, {8'h00, seven_seg(int'(item.value) % 10)}, 8);
               if (item.dot_on)
                  add_action(DISP_DIGITS, ACT_LATCH, 1'b0);
               add_action(DISP_DIGITS, ACT_LATCH, 1'b0);
            end
            OP_ALPHA: begin
               shift_out(DISP_ALPHA, {4'h0, char_glyph(item.value)}, ALPHA_BITS);
               add_action(DISP_ALPHA, ACT_LATCH, 1'b0);
            end
            OP_BAR: begin
               level = (int'(item.value) > BAR_STEPS) ? BAR_STEPS : int'(item.value);
               for (int i = 0; i < BAR_STEPS - level; i++)
                  add_action(DISP_BAR, ACT_SHIFT, 1'b0);
               for (int i = 0; i < level; i++)
                  add_action(DISP_BAR, ACT_SHIFT, 1'b1);
               add_action(DISP_BAR, ACT_LATCH, 1'b0);
            end
            default: ;
         endcase
         if (run.size() == 0)
            return;
         if (item.operation != OP_BAR) begin
            run[0].set_brightness   = 1'b1;
            run[0].brightness_match = MATCH_BASE - pct;
         end
         run[run.size() - 1].last = 1'b1;
         foreach (run[i])
            pending_actions.push_back(run[i]);
      endfunction

      function void compare_field(input string name, input logic [7:0] want_v,
                                  input logic [7:0] got_v);
         if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending_actions.size() == 0) begin
            $error("pin action with nothing expected: %h", got);
            mismatches++;
            return;
         end
         want = pending_actions.pop_front();
         compare_field("display", 8'(want.display), 8'(got.display));
         compare_field("action", 8'(want.action), 8'(got.action));
         compare_field("data_bit", 8'(want.data_bit), 8'(got.data_bit));
         compare_field("set_brightness", 8'(want.set_brightness), 8'(got.set_brightness));
         compare_field("brightness_match", 8'(want.brightness_match),
                       8'(got.brightness_match));
         compare_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   pin_action_board board = new;

   // characters that have a glyph, used for most of the random alpha items
   string glyph_chars = "AaBbCcDdEeFfGgHhIiJjKkLlMmNnOoPpQqRrSsTtUuVvWwXxYyZz0123456789";
   bit    burst = 1'b0;
   int    cycle_count;

   segment_display_shift_driver_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // an item is taken at the edge where start is high and busy low;
   // values read here are the ones from before the edge
   always @(posedge clock) begin
      if (!reset && start && !busy)
         board.note_item(req_data);
   end

   // each strobed pin action is taken at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(rsp_data);
   end

   // idle cycles before the next item: none during a burst stretch
   function automatic int pace();
      return burst ? 0 : $urandom_range(MAX_GAP);
   endfunction

   function automatic req_type make_item(input logic [1:0] op, input logic [7:0] value,
                                         input logic dot, input logic [6:0] pct);
      req_type item;
      item.operation  = op;
      item.value      = value;
      item.dot_on     = dot;
      item.brightness = pct;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      pick;
      pick = $urandom_range(99);
      item.dot_on = 1'($urandom_range(1));
      // brightness mostly in range, sometimes above hundred
      item.brightness = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                                 : 7'($urandom_range(FULL_PERCENT));
      if (pick < 35) begin
         item.operation = OP_DIGITS;
         item.value = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(99));
      end else if (pick < 65) begin
         item.operation = OP_ALPHA;
         item.value = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                      : glyph_chars[$urandom_range(glyph_chars.len() - 1)];
      end else if (pick < 92) begin
         item.operation = OP_BAR;
         item.value = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(BAR_STEPS));
      end else begin
         item.operation = OP_UNUSED;
         item.value = 8'($urandom_range(255));
      end
      return item;
   endfunction

   // start is left high after acceptance so a zero gap streams items back to back
   task automatic send_item(input req_type item, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // stop sending and wait for every expected pin action;
   // one edge first so the item taken at the last edge is already noted
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_actions.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL segment_display_shift_driver_core");
      $finish;
   end

   initial begin
      req_type item;
      int      sent;
      bit      held;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: first few back to back so the command queue fills and busy rises
      burst = 1'b1;
      send_item(make_item(OP_DIGITS, 8'd0, 1'b0, 7'd0), pace());
      send_item(make_item(OP_DIGITS, 8'd99, 1'b1, 7'd100), pace());
      // tens digit above nine, brightness above hundred
      send_item(make_item(OP_DIGITS, 8'd100, 1'b0, 7'd127), pace());
      send_item(make_item(OP_DIGITS, 8'd255, 1'b1, 7'd101), pace());
      send_item(make_item(OP_DIGITS, 8'd47, 1'b1, 7'd50), pace());
      burst = 1'b0;
      send_item(make_item(OP_ALPHA, "A", 1'b0, 7'd1), pace());
      send_item(make_item(OP_ALPHA, "b", 1'b0, 7'd99), pace());
      send_item(make_item(OP_ALPHA, "j", 1'b0, 7'd64), pace());
      send_item(make_item(OP_ALPHA, "X", 1'b0, 7'd0), pace());
      send_item(make_item(OP_ALPHA, "9", 1'b0, 7'd100), pace());
      // unknown characters, low and high codes; dot is ignored off the digits chain
      send_item(make_item(OP_ALPHA, 8'd0, 1'b1, 7'd127), pace());
      send_item(make_item(OP_ALPHA, 8'd127, 1'b0, 7'd33), pace());
      send_item(make_item(OP_ALPHA, 8'd128, 1'b0, 7'd77), pace());
      send_item(make_item(OP_ALPHA, 8'd255, 1'b1, 7'd10), pace());
      send_item(make_item(OP_BAR, 8'd0, 1'b0, 7'd0), pace());
      send_item(make_item(OP_BAR, 8'd10, 1'b0, 7'd100), pace());
      // bar level saturates at ten
      send_item(make_item(OP_BAR, 8'd11, 1'b0, 7'd127), pace());
      send_item(make_item(OP_BAR, 8'd255, 1'b1, 7'd55), pace());
      send_item(make_item(OP_BAR, 8'd5, 1'b1, 7'd42), pace());
      // unused operation produces nothing, the next item must follow cleanly
      send_item(make_item(OP_UNUSED, 8'd255, 1'b1, 7'd127), pace());
      send_item(make_item(OP_DIGITS, 8'd8, 1'b0, 7'd20), pace());

      // sender holds off until the block has emitted everything
      drain();

      // random part: stretches of 40 counted items, every third one streamed with no gaps
      sent = 0;
      held = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = ((sent / 40) % 3 == 1);
         item  = random_item();
         send_item(item, pace());
         if (item.operation != OP_UNUSED)
            sent++;
         if (!held && sent >= RANDOM_ITEMS / 2) begin
            held = 1'b1;
            drain();
         end
      end

      drain();
      // any extra pin action after this point is flagged by the scoreboard
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("PASS segment_display_shift_driver_core");
      else
         $display("FAIL segment_display_shift_driver_core");
      $finish;
   end

endmodule
